/* sv/qpat_pkg.sv */
package qpat_pkg;

    localparam int KEY_W      = 64;
    localparam int PW_W       = 64;
    localparam int STATUS_W   = 3;

    // Home slot: add the residues of eight key bit weights per cycle, lowest
    // bits first, then bring the sum below the table size by compare and subtract
    localparam int HOME_BITS  = 8;
    localparam int FOLD_STEPS = KEY_W / HOME_BITS;
    localparam int FOLD_CW    = $clog2(FOLD_STEPS);
    localparam int BIT_CW     = $clog2(HOME_BITS);
    localparam int RED_PER    = 3;
    localparam int RED_STEPS  = $clog2(KEY_W) / RED_PER;
    localparam int HOME_STEPS = FOLD_STEPS + RED_STEPS;
    localparam int HOME_CW    = $clog2(HOME_STEPS);

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_REGISTERED = 3'd0;
    localparam t_status ST_EXISTS     = 3'd1;
    localparam t_status ST_LOGIN_OK   = 3'd2;
    localparam t_status ST_NO_ACCOUNT = 3'd3;
    localparam t_status ST_WRONG_PW   = 3'd4;
    localparam t_status ST_FULL       = 3'd5;

    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_LOGIN    = 1'b1;

    // One table slot as stored in the slot memory
    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [PW_W-1:0]  pw;
    } t_entry;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    home_step;
        logic    probe_init;
        logic    probe_adv;
        logic    commit;
        logic    emit;
        t_status status;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic home_last;
        logic mode;
        logic slot_used;
        logic stop;
        logic pw_match;
        logic last_probe;
        logic full;
    } t_dp_sts;

endpackage

/* sv/quadratic_probe_account_table.sv */
// Account table with quadratic probing over a single slot memory.
// Command channel: a transaction is accepted on a clock edge where start is
// high and busy is low; i_mode, i_account_key and i_password_word are sampled
// then. Mode 0 registers the key with its password, mode 1 checks a login.
// Result channel: o_status is valid for exactly one cycle while
// o_status_valid is high; the receiver cannot stall and must take it then.
// Sequence: the key is first reduced to its home slot in S_HOME (the fold
// steps add the residues of eight key bits each, the reduction steps bring
// the sum below the table size), then each probe reads the slot memory in
// S_READ and compares in S_CHECK, and busy stays high until the last probe.
// The strobe comes in the first cycle after busy drops, and a new
// transaction may be accepted in that same cycle. Each probe waits for the
// registered read data of the single read port of the slot memory.
// Reset: synchronous, active low. After reset the block sweeps the slot
// memory marking every slot unused, one slot per cycle, with busy high;
// the account count starts at zero.
module quadratic_probe_account_table #(
    parameter int unsigned TABLE_SIZE  = 1031,
    parameter int unsigned MAX_ENTRIES = 515
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [qpat_pkg::KEY_W-1:0]    i_account_key,
    input  logic [qpat_pkg::PW_W-1:0]     i_password_word,
    output logic [qpat_pkg::STATUS_W-1:0] o_status,
    output logic                          o_status_valid
);

    qpat_pkg::t_dp_cmd cmd;
    qpat_pkg::t_dp_sts sts;

    qpat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    qpat_dp #(
        .TABLE_SIZE  (TABLE_SIZE),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_mode),
        .i_account_key   (i_account_key),
        .i_password_word (i_password_word),
        .o_status        (o_status),
        .o_status_valid  (o_status_valid)
    );

endmodule

/* sv/qpat_ram.sv */
module qpat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one port, read the other with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/qpat_dp.sv */
module qpat_dp #(
    parameter int unsigned TABLE_SIZE  = 1031,
    parameter int unsigned MAX_ENTRIES = 515
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  qpat_pkg::t_dp_cmd          i_cmd,
    output qpat_pkg::t_dp_sts          o_sts,
    input  logic                       i_mode,
    input  logic [qpat_pkg::KEY_W-1:0] i_account_key,
    input  logic [qpat_pkg::PW_W-1:0]  i_password_word,
    output logic [qpat_pkg::STATUS_W-1:0] o_status,
    output logic                       o_status_valid
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LOG_KEY = $clog2(qpat_pkg::KEY_W);
    localparam int AW = IW + LOG_KEY;
    localparam int BW = qpat_pkg::BIT_CW;
    localparam int HW = qpat_pkg::HOME_CW;
    localparam int unsigned LAST_SLOT = TABLE_SIZE - 1;
    localparam logic [IW:0]   N_EXT    = TABLE_SIZE[IW:0];
    localparam logic [AW-1:0] N_ACC    = AW'(TABLE_SIZE);
    localparam logic [IW-1:0] LAST_IDX = LAST_SLOT[IW-1:0];
    localparam logic [CW-1:0] MAX_CNT  = MAX_ENTRIES[CW-1:0];
    localparam logic [HW-1:0] HOME_LAST = HW'(qpat_pkg::HOME_STEPS - 1);
    localparam logic [HW-1:0] FOLD_CNT  = HW'(qpat_pkg::FOLD_STEPS);

    typedef logic [qpat_pkg::KEY_W-1:0][IW-1:0] t_residues;

    // Residue of each key bit weight, 2**i mod table size
    function automatic t_residues key_bit_residues();
        t_residues   res;
        int unsigned r;
        res = '0;
        r   = 1 % TABLE_SIZE;
        for (int i = 0; i < qpat_pkg::KEY_W; i++) begin
            res[i] = IW'(r);
            r      = (r * 2) % TABLE_SIZE;
        end
        return res;
    endfunction

    localparam t_residues BIT_RES = key_bit_residues();

    logic                              r_mode;
    logic [qpat_pkg::KEY_W-1:0]        r_key;
    logic [qpat_pkg::PW_W-1:0]         r_pw;
    logic [qpat_pkg::KEY_W-1:0]        r_shift;
    logic [AW-1:0]                     r_acc;
    logic [AW-1:0]                     n_acc;
    logic [qpat_pkg::HOME_CW-1:0]      r_home_cnt;
    logic [IW-1:0]                     r_pos;
    logic [IW-1:0]                     n_pos_adv;
    logic [IW-1:0]                     r_delta;
    logic [IW-1:0]                     n_delta_adv;
    logic [IW-1:0]                     r_probe;
    logic [CW-1:0]                     r_count;
    logic [qpat_pkg::STATUS_W-1:0]     r_status;
    logic                              r_status_valid;
    qpat_pkg::t_entry                  ram_q;
    qpat_pkg::t_entry                  ram_wdata;
    logic                              ram_we;

    // Add the residues of the next key bits, then reduce the sum below the table size
    always_comb begin
        logic [AW-1:0] acc;
        logic [AW-1:0] sub;
        int            sh;
        acc = r_acc;
        sub = '0;
        sh  = 0;
        if (r_home_cnt < FOLD_CNT) begin
            for (int j = 0; j < qpat_pkg::HOME_BITS; j++) begin
                if (r_shift[j]) begin
                    acc = acc + AW'(BIT_RES[{r_home_cnt[qpat_pkg::FOLD_CW-1:0], BW'(j)}]);
                end
            end
        end else begin
            for (int j = 0; j < qpat_pkg::RED_PER; j++) begin
                sh  = LOG_KEY - 1 - j - ((r_home_cnt == FOLD_CNT) ? 0 : qpat_pkg::RED_PER);
                sub = N_ACC << sh;
                if (acc >= sub) begin
                    acc = acc - sub;
                end
            end
        end
        n_acc = acc;
    end

    // Step to the next quadratic probe: pos += 2c+1, delta += 2, both mod size
    always_comb begin
        logic [IW:0] s;
        logic [IW:0] d;
        s = {1'b0, r_pos} + {1'b0, r_delta};
        if (s >= N_EXT) begin
            s = s - N_EXT;
        end
        d = {1'b0, r_delta} + (IW+1)'(2);
        if (d >= N_EXT) begin
            d = d - N_EXT;
        end
        n_pos_adv   = s[IW-1:0];
        n_delta_adv = d[IW-1:0];
    end

    // Capture the transaction and run the home slot reduction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_key   <= i_account_key;
            r_pw    <= i_password_word;
            r_shift <= i_account_key;
            r_acc   <= '0;
        end else if (i_cmd.home_step) begin
            r_shift <= {{qpat_pkg::HOME_BITS{1'b0}},
                        r_shift[qpat_pkg::KEY_W-1:qpat_pkg::HOME_BITS]};
            r_acc   <= n_acc;
        end
    end

    // Advance the home step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_cnt <= '0;
        end else if (i_cmd.load) begin
            r_home_cnt <= '0;
        end else if (i_cmd.home_step) begin
            r_home_cnt <= r_home_cnt + 1'b1;
        end
    end

    // Slot pointer: clearing sweep after reset, then probe position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_delta <= '0;
            r_probe <= '0;
        end else if (i_cmd.clr_step) begin
            r_pos <= r_pos + 1'b1;
        end else if (i_cmd.probe_init) begin
            r_pos   <= n_acc[IW-1:0];
            r_delta <= IW'(1);
            r_probe <= '0;
        end else if (i_cmd.probe_adv) begin
            r_pos   <= n_pos_adv;
            r_delta <= n_delta_adv;
            r_probe <= r_probe + 1'b1;
        end
    end

    // Count stored accounts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Register the result strobe and code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_valid <= 1'b0;
        end else begin
            r_status_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
        end
    end

    // Slot memory: clear writes an unused entry, commit stores the account
    always_comb begin
        ram_wdata      = '0;
        ram_wdata.used = i_cmd.commit;
        ram_wdata.key  = r_key;
        ram_wdata.pw   = r_pw;
        ram_we         = i_cmd.clr_step | i_cmd.commit;
    end

    qpat_ram #(
        .WIDTH ($bits(qpat_pkg::t_entry)),
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (ram_wdata),
        .i_raddr (r_pos),
        .o_rdata (ram_q)
    );

    // Report flags to the controller
    always_comb begin
        o_sts.clr_last   = (r_pos == LAST_IDX);
        o_sts.home_last  = (r_home_cnt == HOME_LAST);
        o_sts.mode       = r_mode;
        o_sts.slot_used  = ram_q.used;
        o_sts.stop       = !ram_q.used || (ram_q.key == r_key);
        o_sts.pw_match   = (ram_q.pw == r_pw);
        o_sts.last_probe = (r_probe == LAST_IDX);
        o_sts.full       = (r_count >= MAX_CNT);
    end

    assign o_status       = r_status;
    assign o_status_valid = r_status_valid;

endmodule

/* sv/qpat_ctrl.sv */
module qpat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  qpat_pkg::t_dp_sts i_sts,
    output qpat_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HOME  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence clearing, home reduction and the probe loop
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HOME;
                end
            end
            S_HOME: begin
                o_cmd.home_step = 1'b1;
                if (i_sts.home_last) begin
                    o_cmd.probe_init = 1'b1;
                    n_state          = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.stop || i_sts.last_probe) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    if (i_sts.mode == qpat_pkg::MODE_REGISTER) begin
                        // Duplicate check comes before the full check
                        if (i_sts.stop && i_sts.slot_used) begin
                            o_cmd.status = qpat_pkg::ST_EXISTS;
                        end else if (!i_sts.stop || i_sts.full) begin
                            o_cmd.status = qpat_pkg::ST_FULL;
                        end else begin
                            o_cmd.commit = 1'b1;
                            o_cmd.status = qpat_pkg::ST_REGISTERED;
                        end
                    end else begin
                        if (!i_sts.stop || !i_sts.slot_used) begin
                            o_cmd.status = qpat_pkg::ST_NO_ACCOUNT;
                        end else if (i_sts.pw_match) begin
                            o_cmd.status = qpat_pkg::ST_LOGIN_OK;
                        end else begin
                            o_cmd.status = qpat_pkg::ST_WRONG_PW;
                        end
                    end
                end else begin
                    o_cmd.probe_adv = 1'b1;
                    n_state         = S_READ;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

/* tb/account_table_checker.sv */
module account_table_checker
    import qpat_pkg::*;
#(
    parameter int unsigned TABLE_SIZE  = 1031,
    parameter int unsigned MAX_ENTRIES = 515
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                i_mode,
    input  logic [KEY_W-1:0]    i_account_key,
    input  logic [PW_W-1:0]     i_password_word,
    input  logic [STATUS_W-1:0] i_status,
    input  logic                i_status_valid,
    output int                  o_fail_count,
    output int                  o_pending
);

    // Shadow copy of the slot memory and the account count
    bit                tbl_used [TABLE_SIZE];
    logic [KEY_W-1:0]  tbl_key  [TABLE_SIZE];
    logic [PW_W-1:0]   tbl_pw   [TABLE_SIZE];
    int unsigned       tbl_count;

    t_status expected_status_q[$];
    int      result_index;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        result_index = 0;
    end

    task automatic report_error(input string what, input t_status got, input t_status want);
        $display("ERROR t=%0t result %0d: %s (got %0d, want %0d)",
                 $time, result_index, what, got, want);
        o_fail_count++;
    endtask

    // Walk the quadratic probe sequence; stop at a free slot or the matching key
    function automatic bit find_slot(input logic [KEY_W-1:0] key, output int unsigned slot);
        logic [63:0] home;
        logic [63:0] pos;
        int unsigned c;
        home = key % 64'(TABLE_SIZE);
        slot = 0;
        for (c = 0; c < TABLE_SIZE; c++) begin
            pos = (home + (64'(c) * 64'(c)) % 64'(TABLE_SIZE)) % 64'(TABLE_SIZE);
            if (!tbl_used[pos] || tbl_key[pos] == key) begin
                slot = int'(pos);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Work out the status of one transaction and update the shadow table
    function automatic t_status next_status(input logic mode, input logic [KEY_W-1:0] key,
                                            input logic [PW_W-1:0] pw);
        int unsigned slot;
        bit          hit;
        t_status     st;
        hit = find_slot(key, slot);
        if (mode == MODE_REGISTER) begin
            if (hit && tbl_used[slot]) begin
                st = ST_EXISTS;
            end else if (!hit || tbl_count >= MAX_ENTRIES) begin
                st = ST_FULL;
            end else begin
                tbl_used[slot] = 1'b1;
                tbl_key[slot]  = key;
                tbl_pw[slot]   = pw;
                tbl_count++;
                st = ST_REGISTERED;
            end
        end else begin
            if (!hit || !tbl_used[slot]) begin
                st = ST_NO_ACCOUNT;
            end else if (tbl_pw[slot] == pw) begin
                st = ST_LOGIN_OK;
            end else begin
                st = ST_WRONG_PW;
            end
        end
        return st;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Clear the shadow table and drop anything pending
            for (int i = 0; i < TABLE_SIZE; i++) begin
                tbl_used[i] = 1'b0;
                tbl_key[i]  = '0;
                tbl_pw[i]   = '0;
            end
            tbl_count = 0;
            expected_status_q.delete();
        end else begin
            // Compare the result first: it belongs to an earlier transaction
            if (i_status_valid !== 1'b0) begin
                if (i_status_valid !== 1'b1) begin
                    report_error("strobe unknown", i_status, i_status);
                end else if (expected_status_q.size() == 0) begin
                    report_error("result with nothing expected", i_status, i_status);
                end else begin
                    t_status want;
                    want = expected_status_q.pop_front();
                    if (i_status !== want) begin
                        report_error("status mismatch", i_status, want);
                    end
                end
                result_index++;
            end
            // Predict each accepted transaction
            if (start && busy === 1'b0) begin
                expected_status_q.push_back(next_status(i_mode, i_account_key,
                                                        i_password_word));
            end
        end
        o_pending = expected_status_q.size();
    end

endmodule

/* tb/testbench.sv */
module testbench;
    import qpat_pkg::*;

    localparam int unsigned SLOTS         = 1031;
    localparam int unsigned ACCOUNT_LIMIT = 515;
    localparam int          RANDOM_ITEMS  = 1900;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                start           = 1'b0;
    logic                busy;
    logic                i_mode          = MODE_REGISTER;
    logic [KEY_W-1:0]    i_account_key   = '0;
    logic [PW_W-1:0]     i_password_word = '0;
    logic [STATUS_W-1:0] o_status;
    logic                o_status_valid;

    int fail_count;
    int pending;

    // Keys sent for registration, with the first password given for each
    logic [KEY_W-1:0] known_key[$];
    logic [PW_W-1:0]  known_pw[$];

    // Homes shared by many keys to build long probe chains, wrap included
    int unsigned cluster_home[8] = '{0, 1, 3, 500, 512, 777, 1029, 1030};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    quadratic_probe_account_table #(
        .TABLE_SIZE  (SLOTS),
        .MAX_ENTRIES (ACCOUNT_LIMIT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_account_key   (i_account_key),
        .i_password_word (i_password_word),
        .o_status        (o_status),
        .o_status_valid  (o_status_valid)
    );

    account_table_checker #(
        .TABLE_SIZE  (SLOTS),
        .MAX_ENTRIES (ACCOUNT_LIMIT)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_account_key   (i_account_key),
        .i_password_word (i_password_word),
        .i_status        (o_status),
        .i_status_valid  (o_status_valid),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Present one transaction and hold it until busy is low at an edge
    task automatic send_item(input logic mode, input logic [KEY_W-1:0] key,
                             input logic [PW_W-1:0] pw);
        start           <= 1'b1;
        i_mode          <= mode;
        i_account_key   <= key;
        i_password_word <= pw;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Hold off until every expected status has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Fresh key: full-width random, clustered on a shared home, or near the top
    function automatic logic [KEY_W-1:0] fresh_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return {$urandom, $urandom};
        if (r < 9) return 64'(cluster_home[$urandom_range(0, 7)])
                          + 64'(SLOTS) * 64'($urandom_range(1, 1 << 20));
        return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 5000));
    endfunction

    task automatic register_new(input logic [KEY_W-1:0] key, input logic [PW_W-1:0] pw);
        known_key.push_back(key);
        known_pw.push_back(pw);
        send_item(MODE_REGISTER, key, pw);
    endtask

    initial begin
        int               n;
        int               op;
        int               idx;
        int               waited;
        bit               steady;
        logic [KEY_W-1:0] key;
        logic [PW_W-1:0]  pw;

        steady = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme keys and passwords, every status but full, collisions and wrap
        send_item(MODE_LOGIN, 64'd0, 64'd0);
        register_new(64'd0, 64'd0);
        register_new(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(MODE_LOGIN, 64'd0, 64'd0);
        idle_for(2);
        send_item(MODE_LOGIN, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(MODE_LOGIN, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(MODE_LOGIN, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_item(MODE_REGISTER, 64'd0, 64'd5);
        register_new(64'(SLOTS), 64'hAAAA_AAAA_AAAA_AAAA);
        register_new(64'(2 * SLOTS), 64'h5555_5555_5555_5555);
        idle_for(1);
        send_item(MODE_LOGIN, 64'(SLOTS), 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(MODE_LOGIN, 64'(2 * SLOTS), 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(MODE_LOGIN, 64'(3 * SLOTS), 64'h5555_5555_5555_5555);
        // Top key bit set: the home slot must come from the unsigned key
        register_new(64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF);
        send_item(MODE_LOGIN, 64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF);
        // Home in the last slot; the second probe wraps to slot zero
        register_new(64'(SLOTS - 1), 64'hFEDC_BA98_7654_3210);
        register_new(64'(2 * SLOTS - 1), 64'h8000_0000_0000_0001);
        idle_for(25);
        send_item(MODE_LOGIN, 64'(2 * SLOTS - 1), 64'h8000_0000_0000_0001);
        send_item(MODE_REGISTER, 64'(2 * SLOTS - 1), 64'd1);
        wait_drained();

        // Random: fill the table past its load limit, then keep mixing
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) steady = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_ITEMS / 2) wait_drained();
            op  = $urandom_range(0, 99);
            idx = $urandom_range(0, known_key.size() - 1);
            if (op < 45) begin
                register_new(fresh_key(), {$urandom, $urandom});
            end else if (op < 55) begin
                send_item(MODE_REGISTER, known_key[idx], {$urandom, $urandom});
            end else if (op < 78) begin
                send_item(MODE_LOGIN, known_key[idx], known_pw[idx]);
            end else if (op < 88) begin
                pw = known_pw[idx] ^ (64'd1 << $urandom_range(0, 63));
                send_item(MODE_LOGIN, known_key[idx], pw);
            end else begin
                key = fresh_key();
                send_item(MODE_LOGIN, key, {$urandom, $urandom});
            end
            idle_for(pick_gap(steady));
        end

        // Drain with a bound, then allow the tail latency
        start  <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #240_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
